@@ rtl/vat_pkg.sv @@
// vat_pkg: shared types, constants and helpers for the vertex affine transform
// holds the vertex payload structs, mode and register codes, cordic table and saturation
// depends on nothing
package vat_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int TRIG_FRAC       = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_W        = 20;
  localparam int ANGLE_Z_W       = 25;
  localparam int TRIG_W          = 18;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 20'sd39796;
  localparam logic signed [CORDIC_W-1:0] TRIG_ONE    = 20'sd65536;

  localparam logic signed [18:0] DEG_180 = 19'sd46080;
  localparam logic signed [18:0] DEG_90  = 19'sd23040;
  localparam logic signed [18:0] DEG_360 = 19'sd92160;

  // arctangent of 2^-i in degrees, 16 fraction bits
  localparam logic signed [ANGLE_Z_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115
  };

  typedef enum logic [2:0] {
    MODE_ROTX   = 3'd0,
    MODE_ROTY   = 3'd1,
    MODE_ROTZ   = 3'd2,
    MODE_SCALE  = 3'd3,
    MODE_TRANSX = 3'd4,
    MODE_TRANSY = 3'd5,
    MODE_TRANSZ = 3'd6
  } vat_mode_t;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_ANGLE  = 2'd1;
  localparam logic [1:0] REG_FACTOR = 2'd2;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic               in_last;
  } vat_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_last;
  } vat_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/vertex_affine_transform.sv @@
// vertex_affine_transform: rotate, scale or translate a stream of q16.16 vertices
// four-stage multiply/add pipeline plus an iterative cordic for the held sine and cosine
// depends on vat_pkg
//
// usage:
//  - input: a vertex transfer happens at a rising edge with start high and busy low
//  - output: each result is on out_vertex for exactly one cycle with out_strobe high;
//    the receiver takes it at the edge that ends that cycle and cannot stall the block
//  - config: cfg_we writes cfg_data into register cfg_index (0 mode, 1 angle, 2 factor)
//    at a rising edge; index 3 is ignored; the user must write only while no vertex is in flight (not enforced)
//  - throughput: one vertex per clock while busy is low; the pipeline never stalls
//  - a vertex passes through the input register, multipliers, rounding adders and the
//    shift/saturate/select output register on its way to out_vertex
//  - an angle write starts a 16-step cordic on a shared shift/add unit; busy stays high
//    from the write edge through the 16 iterations and the clamp/store step
//  - reset (synchronous, rst_n low) empties the pipeline, stops the cordic and loads
//    mode rotx, factor 1.0, sine 0 and cosine 1.0
module vertex_affine_transform
  import vat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  vat_in_t     in_vertex,
  output logic        out_strobe,
  output vat_out_t    out_vertex,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration and held trig values
  vat_mode_t                 mode_r;
  logic signed [31:0]        factor_r;
  logic signed [TRIG_W-1:0]  sine_r;
  logic signed [TRIG_W-1:0]  cosine_r;

  // cordic unit
  logic                       cor_run_r;
  logic                       cor_fin_r;
  logic                       cor_neg_r;
  logic [3:0]                 cor_iter_r;
  logic signed [CORDIC_W-1:0] cor_x_r;
  logic signed [CORDIC_W-1:0] cor_y_r;
  logic signed [ANGLE_Z_W-1:0] cor_z_r;

  // pipeline stage 1: input register
  logic               s1_valid_r;
  vat_in_t            s1_vtx_r;

  // pipeline stage 2: products
  logic               s2_valid_r;
  vat_in_t            s2_vtx_r;
  logic signed [49:0] s2_pc_r, s2_qs_r, s2_ps_r, s2_qc_r;
  logic signed [63:0] s2_kx_r, s2_ky_r, s2_kz_r;
  logic signed [32:0] s2_tr_r;

  // pipeline stage 3: rounded sums
  logic               s3_valid_r;
  vat_in_t            s3_vtx_r;
  logic signed [50:0] s3_np_r, s3_nq_r;
  logic signed [63:0] s3_sx_r, s3_sy_r, s3_sz_r;
  logic signed [32:0] s3_tr_r;

  // output register
  logic               out_strobe_r;
  vat_out_t           out_vertex_r;

  logic in_xfer;

  assign busy    = cor_run_r | cor_fin_r;
  assign in_xfer = start & ~busy;

  // ---------------------------------------------------------------------------
  // angle reduction on the write cycle: wrap into [-180,180), fold into [-90,90]
  // ---------------------------------------------------------------------------
  logic signed [18:0]          ang_raw;
  logic signed [18:0]          ang_wrap;
  logic signed [18:0]          ang_fold;
  logic                        ang_neg;
  logic signed [ANGLE_Z_W-1:0] ang_z;

  always_comb begin
    ang_raw = 19'(signed'(cfg_data[17:0]));
    if (ang_raw >= DEG_180) begin
      ang_wrap = ang_raw - DEG_360;
    end else if (ang_raw < -DEG_180) begin
      ang_wrap = ang_raw + DEG_360;
    end else begin
      ang_wrap = ang_raw;
    end
    ang_neg = 1'b0;
    if (ang_wrap > DEG_90) begin
      ang_fold = ang_wrap - DEG_180;
      ang_neg  = 1'b1;
    end else if (ang_wrap < -DEG_90) begin
      ang_fold = ang_wrap + DEG_180;
      ang_neg  = 1'b1;
    end else begin
      ang_fold = ang_wrap;
    end
    // degrees in 1/256 units to 16 fraction bits
    ang_z = ANGLE_Z_W'(ang_fold) <<< 8;
  end

  // ---------------------------------------------------------------------------
  // one cordic micro-rotation per cycle
  // ---------------------------------------------------------------------------
  logic signed [CORDIC_W-1:0]  cor_x_nxt, cor_y_nxt;
  logic signed [ANGLE_Z_W-1:0] cor_z_nxt;
  logic signed [CORDIC_W-1:0]  cor_dx, cor_dy;

  always_comb begin
    cor_dx = cor_y_r >>> cor_iter_r;
    cor_dy = cor_x_r >>> cor_iter_r;
    if (cor_z_r >= 0) begin
      cor_x_nxt = cor_x_r - cor_dx;
      cor_y_nxt = cor_y_r + cor_dy;
      cor_z_nxt = cor_z_r - ATAN_DEG[cor_iter_r];
    end else begin
      cor_x_nxt = cor_x_r + cor_dx;
      cor_y_nxt = cor_y_r - cor_dy;
      cor_z_nxt = cor_z_r + ATAN_DEG[cor_iter_r];
    end
  end

  // clamp to [-1,1] and undo the fold
  logic signed [CORDIC_W-1:0] cos_clamp, sin_clamp;
  logic signed [CORDIC_W-1:0] cos_final, sin_final;

  always_comb begin
    if (cor_x_r > TRIG_ONE) begin
      cos_clamp = TRIG_ONE;
    end else if (cor_x_r < -TRIG_ONE) begin
      cos_clamp = -TRIG_ONE;
    end else begin
      cos_clamp = cor_x_r;
    end
    if (cor_y_r > TRIG_ONE) begin
      sin_clamp = TRIG_ONE;
    end else if (cor_y_r < -TRIG_ONE) begin
      sin_clamp = -TRIG_ONE;
    end else begin
      sin_clamp = cor_y_r;
    end
    cos_final = cor_neg_r ? -cos_clamp : cos_clamp;
    sin_final = cor_neg_r ? -sin_clamp : sin_clamp;
  end

  // configuration registers and the cordic sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ROTX;
      factor_r   <= 32'sd1 <<< COORD_FRAC_BITS;
      sine_r     <= '0;
      cosine_r   <= TRIG_W'(TRIG_ONE);
      cor_run_r  <= 1'b0;
      cor_fin_r  <= 1'b0;
      cor_iter_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode_r <= vat_mode_t'(cfg_data[2:0]);
          REG_ANGLE: begin
            cor_run_r  <= 1'b1;
            cor_iter_r <= '0;
          end
          REG_FACTOR: factor_r <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (cor_run_r) begin
        cor_iter_r <= cor_iter_r + 4'd1;
        if (cor_iter_r == 4'(CORDIC_STEPS - 1)) begin
          cor_run_r <= 1'b0;
          cor_fin_r <= 1'b1;
        end
      end
      if (cor_fin_r) begin
        cor_fin_r <= 1'b0;
        cosine_r  <= TRIG_W'(cos_final);
        sine_r    <= TRIG_W'(sin_final);
      end
    end
  end

  // cordic datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index == REG_ANGLE) begin
      cor_x_r   <= CORDIC_GAIN;
      cor_y_r   <= '0;
      cor_z_r   <= ang_z;
      cor_neg_r <= ang_neg;
    end else if (cor_run_r) begin
      cor_x_r <= cor_x_nxt;
      cor_y_r <= cor_y_nxt;
      cor_z_r <= cor_z_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: operand select and multiply
  // ---------------------------------------------------------------------------
  logic signed [31:0] rot_p, rot_q;
  logic signed [31:0] tr_sel;

  always_comb begin
    case (mode_r)
      MODE_ROTY: begin
        rot_p = s1_vtx_r.in_x;
        rot_q = s1_vtx_r.in_z;
      end
      MODE_ROTZ: begin
        rot_p = s1_vtx_r.in_x;
        rot_q = s1_vtx_r.in_y;
      end
      default: begin
        rot_p = s1_vtx_r.in_y;
        rot_q = s1_vtx_r.in_z;
      end
    endcase
    case (mode_r)
      MODE_TRANSY: tr_sel = s1_vtx_r.in_y;
      MODE_TRANSZ: tr_sel = s1_vtx_r.in_z;
      default:     tr_sel = s1_vtx_r.in_x;
    endcase
  end

  // ---------------------------------------------------------------------------
  // stage 4: shift back to the coordinate format, saturate and pick per mode
  // ---------------------------------------------------------------------------
  localparam logic signed [50:0] ROT_HALF   = 51'sd1 <<< (TRIG_FRAC - 1);
  localparam logic signed [63:0] SCALE_HALF = 64'sd1 <<< (COORD_FRAC_BITS - 1);

  logic signed [31:0] np_sat, nq_sat, sx_sat, sy_sat, sz_sat, tr_sat;
  vat_out_t           res;

  always_comb begin
    np_sat = sat32(64'(s3_np_r >>> TRIG_FRAC));
    nq_sat = sat32(64'(s3_nq_r >>> TRIG_FRAC));
    sx_sat = sat32(s3_sx_r >>> COORD_FRAC_BITS);
    sy_sat = sat32(s3_sy_r >>> COORD_FRAC_BITS);
    sz_sat = sat32(s3_sz_r >>> COORD_FRAC_BITS);
    tr_sat = sat32(64'(s3_tr_r));

    res.out_x    = s3_vtx_r.in_x;
    res.out_y    = s3_vtx_r.in_y;
    res.out_z    = s3_vtx_r.in_z;
    res.out_last = s3_vtx_r.in_last;
    case (mode_r)
      MODE_ROTX: begin
        res.out_y = np_sat;
        res.out_z = nq_sat;
      end
      MODE_ROTY: begin
        res.out_x = np_sat;
        res.out_z = nq_sat;
      end
      MODE_ROTZ: begin
        res.out_x = np_sat;
        res.out_y = nq_sat;
      end
      MODE_SCALE: begin
        // a zero factor leaves the vertex alone
        if (factor_r != 32'sd0) begin
          res.out_x = sx_sat;
          res.out_y = sy_sat;
          res.out_z = sz_sat;
        end
      end
      MODE_TRANSX: res.out_x = tr_sat;
      MODE_TRANSY: res.out_y = tr_sat;
      MODE_TRANSZ: res.out_z = tr_sat;
      default: ;
    endcase
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= in_xfer;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      out_strobe_r <= s3_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_vtx_r <= in_vertex;
    end
    if (s1_valid_r) begin
      s2_vtx_r <= s1_vtx_r;
      s2_pc_r  <= rot_p * cosine_r;
      s2_qs_r  <= rot_q * sine_r;
      s2_ps_r  <= rot_p * sine_r;
      s2_qc_r  <= rot_q * cosine_r;
      s2_kx_r  <= s1_vtx_r.in_x * factor_r;
      s2_ky_r  <= s1_vtx_r.in_y * factor_r;
      s2_kz_r  <= s1_vtx_r.in_z * factor_r;
      s2_tr_r  <= 33'(tr_sel) + 33'(factor_r);
    end
    if (s2_valid_r) begin
      s3_vtx_r <= s2_vtx_r;
      s3_np_r  <= 51'(s2_pc_r) + 51'(s2_qs_r) + ROT_HALF;
      s3_nq_r  <= 51'(s2_qc_r) - 51'(s2_ps_r) + ROT_HALF;
      s3_sx_r  <= s2_kx_r + SCALE_HALF;
      s3_sy_r  <= s2_ky_r + SCALE_HALF;
      s3_sz_r  <= s2_kz_r + SCALE_HALF;
      s3_tr_r  <= s2_tr_r;
    end
    if (s3_valid_r) begin
      out_vertex_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_vertex = out_vertex_r;

endmodule

@@ dv/vertex_affine_transform_checker.sv @@
// vertex_affine_transform_checker: predicts each transformed vertex and compares the results
// watches the vertex, result and register write ports of vertex_affine_transform
// depends on vat_pkg
module vertex_affine_transform_checker
  import vat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  vat_in_t     in_vertex,
  input  logic        out_strobe,
  input  vat_out_t    out_vertex,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatch_count,
  output int          outstanding
);

  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;
  localparam longint TURN_FULL    = 92160;
  localparam longint TURN_HALF    = 46080;
  localparam longint TURN_QUARTER = 23040;
  localparam longint GAIN_START   = 39796;
  localparam longint TRIG_UNITY   = 65536;
  localparam longint TRIG_ROUND   = 32768;

  typedef struct packed {
    longint sine;
    longint cosine;
  } trig_pair_t;

  // atan(2^-i) in degrees, 16 fraction bits
  longint atan_deg_q16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic [2:0]         mode_q;
  logic signed [31:0] factor_q;
  logic signed [17:0] sine_q;
  logic signed [17:0] cosine_q;
  vat_out_t           expected_vertices [$];
  int                 result_index;

  task automatic report_mismatch(input string msg);
    $display("vertex check: result %0d: %s", result_index, msg);
    mismatch_count++;
  endtask

  function automatic longint clip_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic trig_pair_t cordic_trig(input logic signed [17:0] ang);
    longint     a, x, y, z, dx, dy;
    bit         flip;
    int         i;
    trig_pair_t r;
    a = ang;
    flip = 1'b0;
    while (a >= TURN_HALF) a -= TURN_FULL;
    while (a < -TURN_HALF) a += TURN_FULL;
    // fold into [-90, 90] and negate both results afterwards
    if (a > TURN_QUARTER) begin
      a -= TURN_HALF;
      flip = 1'b1;
    end else if (a < -TURN_QUARTER) begin
      a += TURN_HALF;
      flip = 1'b1;
    end
    x = GAIN_START;
    y = 0;
    z = a * 256;
    for (i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_deg_q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_deg_q16[i];
      end
    end
    if (x > TRIG_UNITY) x = TRIG_UNITY;
    else if (x < -TRIG_UNITY) x = -TRIG_UNITY;
    if (y > TRIG_UNITY) y = TRIG_UNITY;
    else if (y < -TRIG_UNITY) y = -TRIG_UNITY;
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.sine = y;
    r.cosine = x;
    return r;
  endfunction

  // a*ka + b*kb, rounded at the trig fraction point and saturated
  function automatic longint rotate_term(input longint a, input longint b,
                                         input longint ka, input longint kb);
    return clip_word((a * ka + b * kb + TRIG_ROUND) >>> 16);
  endfunction

  function automatic longint scale_term(input longint c, input longint k);
    return clip_word((c * k + (64'sd1 <<< (COORD_FRAC_BITS - 1))) >>> COORD_FRAC_BITS);
  endfunction

  function automatic vat_out_t predict_vertex(input vat_in_t v);
    longint   x, y, z, k, sn, cs, p;
    vat_out_t r;
    x = $signed(v.in_x);
    y = $signed(v.in_y);
    z = $signed(v.in_z);
    k = factor_q;
    sn = sine_q;
    cs = cosine_q;
    case (mode_q)
      MODE_ROTX: begin
        p = y;
        y = rotate_term(p, z, cs, sn);
        z = rotate_term(z, p, cs, -sn);
      end
      MODE_ROTY: begin
        p = x;
        x = rotate_term(p, z, cs, sn);
        z = rotate_term(z, p, cs, -sn);
      end
      MODE_ROTZ: begin
        p = x;
        x = rotate_term(p, y, cs, sn);
        y = rotate_term(y, p, cs, -sn);
      end
      MODE_SCALE: begin
        if (k != 0) begin
          x = scale_term(x, k);
          y = scale_term(y, k);
          z = scale_term(z, k);
        end
      end
      MODE_TRANSX: x = clip_word(x + k);
      MODE_TRANSY: y = clip_word(y + k);
      MODE_TRANSZ: z = clip_word(z + k);
      default: ;
    endcase
    r.out_x = x[31:0];
    r.out_y = y[31:0];
    r.out_z = z[31:0];
    r.out_last = v.in_last;
    return r;
  endfunction

  always @(posedge clk) begin
    vat_out_t   want;
    trig_pair_t tp;
    if (!rst_n) begin
      mode_q = MODE_ROTX;
      factor_q = 32'sd65536;
      sine_q = '0;
      cosine_q = 18'sd65536;
      expected_vertices.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode_q = cfg_data[2:0];
          REG_ANGLE: begin
            tp = cordic_trig(cfg_data[17:0]);
            sine_q = tp.sine[17:0];
            cosine_q = tp.cosine[17:0];
          end
          REG_FACTOR: factor_q = cfg_data;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("result with no vertex outstanding");
        end else begin
          want = expected_vertices.pop_front();
          if (out_vertex.out_x !== want.out_x)
            report_mismatch($sformatf("out_x got %0d expected %0d",
                                      out_vertex.out_x, want.out_x));
          if (out_vertex.out_y !== want.out_y)
            report_mismatch($sformatf("out_y got %0d expected %0d",
                                      out_vertex.out_y, want.out_y));
          if (out_vertex.out_z !== want.out_z)
            report_mismatch($sformatf("out_z got %0d expected %0d",
                                      out_vertex.out_z, want.out_z));
          if (out_vertex.out_last !== want.out_last)
            report_mismatch($sformatf("out_last got %0b expected %0b",
                                      out_vertex.out_last, want.out_last));
        end
        result_index++;
      end
      if (start && !busy)
        expected_vertices.push_back(predict_vertex(in_vertex));
    end
    outstanding <= expected_vertices.size();
  end

endmodule

@@ dv/vertex_affine_transform_test.sv @@
// vertex_affine_transform_test: top of the vertex transform testbench
// drives vertices and register writes into vertex_affine_transform and gives the verdict
// depends on vat_pkg, vertex_affine_transform and vertex_affine_transform_checker
module vertex_affine_transform_test;
  import vat_pkg::*;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          FLUSH_CYCLES = 8;
  localparam int          SEGMENTS     = 24;
  localparam int          SEG_ITEMS    = 84;
  localparam logic [2:0]  MODE_UNUSED  = 3'd7;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam logic [31:0] COORD_MAX    = 32'h7fffffff;
  localparam logic [31:0] COORD_MIN    = 32'h80000000;
  localparam logic [31:0] ONE_Q16      = 32'h00010000;
  localparam int          ANG_360      = 92160;
  localparam int          ANG_180      = 46080;
  localparam int          ANG_90       = 23040;
  localparam int          ANG_45       = 11520;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  vat_in_t     in_vertex;
  logic        out_strobe;
  vat_out_t    out_vertex;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatch_count;
  int          outstanding;
  int          idle_cycles;
  int          idle_pct;

  vertex_affine_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_vertex  (in_vertex),
    .out_strobe (out_strobe),
    .out_vertex (out_vertex),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  vertex_affine_transform_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_vertex      (in_vertex),
    .out_strobe     (out_strobe),
    .out_vertex     (out_vertex),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: any vertex transfer, result or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // coordinates: extremes, zero, small signed values and full-width noise
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(0, 9))
      0: c = COORD_MAX;
      1: c = COORD_MIN;
      2: c = '0;
      3, 4: begin
        c = $urandom_range(0, 32'h000fffff);
        if ($urandom_range(0, 1) == 1) c = -c;
      end
      default: c = $urandom();
    endcase
    return c;
  endfunction

  // angles in 1/256 degree: wrap and fold boundaries or anything in range
  function automatic logic [31:0] rand_angle();
    int a;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: a = ANG_360;
        1: a = -ANG_360;
        2: a = ANG_180;
        3: a = -ANG_180;
        4: a = ANG_90;
        5: a = -ANG_90;
        6: a = ANG_90 + 1;
        default: a = 0;
      endcase
    end else begin
      a = $urandom_range(0, 2 * ANG_360) - ANG_360;
    end
    return a;
  endfunction

  // factors near unity so scaled vertices stay in range, plus zero, the extremes and full-width noise
  function automatic logic [31:0] rand_factor();
    logic [31:0] f;
    case ($urandom_range(0, 7))
      0: f = '0;
      1: f = COORD_MAX;
      2: f = COORD_MIN;
      3: f = ONE_Q16;
      4, 5: f = $urandom_range(0, 32'h00040000) - 32'h00020000;
      default: f = $urandom();
    endcase
    return f;
  endfunction

  // present one vertex and hold it until the transfer edge
  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
    start <= 1'b1;
    in_vertex <= {x, y, z, last};
    do @(posedge clk); while (busy);
  endtask

  // wait for every predicted result and for the cordic to settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // register writes only happen with the pipeline empty
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int         seg;
    int         item;
    logic [2:0] m;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_vertex = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: rotate about x by zero, so vertices pass through
    send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, 32'hffffffff, 1'b0);

    // quarter turn about x, negating the most negative y saturates z
    cfg_write(REG_ANGLE, ANG_90);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(32'h00012345, COORD_MAX, COORD_MIN, 1'b0);

    // half turn sits on the wrap boundary, full turns wrap around
    cfg_write(REG_MODE, {29'd0, MODE_ROTY});
    cfg_write(REG_ANGLE, ANG_180);
    send_vertex(COORD_MAX, '0, COORD_MIN, 1'b0);
    cfg_write(REG_ANGLE, -ANG_180);
    send_vertex(COORD_MAX, 32'h00000001, COORD_MIN, 1'b0);
    cfg_write(REG_ANGLE, -ANG_360);
    send_vertex(COORD_MIN, 32'h00000001, COORD_MAX, 1'b0);

    // just past a quarter turn forces the fold and sign flip
    cfg_write(REG_MODE, {29'd0, MODE_ROTZ});
    cfg_write(REG_ANGLE, ANG_90 + 1);
    send_vertex(COORD_MAX, COORD_MAX, 32'h00000005, 1'b0);
    cfg_write(REG_ANGLE, -ANG_90 - 1);
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b0);
    cfg_write(REG_ANGLE, ANG_360);
    send_vertex(32'h0001e240, 32'hfff6030f, 32'h00000001, 1'b0);
    cfg_write(REG_ANGLE, ANG_45);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);

    // zero scale factor leaves the vertex alone
    cfg_write(REG_MODE, {29'd0, MODE_SCALE});
    cfg_write(REG_FACTOR, '0);
    send_vertex(COORD_MAX, COORD_MIN, 32'h00003039, 1'b0);
    cfg_write(REG_FACTOR, COORD_MAX);
    send_vertex(COORD_MAX, COORD_MIN, 32'h00000001, 1'b0);
    cfg_write(REG_FACTOR, COORD_MIN);
    send_vertex(COORD_MIN, COORD_MAX, 32'hffffffff, 1'b0);
    cfg_write(REG_FACTOR, -ONE_Q16);
    send_vertex(COORD_MIN, ONE_Q16, 32'hfffffffd, 1'b0);

    // translations saturate in both directions
    cfg_write(REG_MODE, {29'd0, MODE_TRANSX});
    cfg_write(REG_FACTOR, COORD_MAX);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    cfg_write(REG_MODE, {29'd0, MODE_TRANSY});
    cfg_write(REG_FACTOR, COORD_MIN);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
    cfg_write(REG_MODE, {29'd0, MODE_TRANSZ});
    cfg_write(REG_FACTOR, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);

    // unused mode passes through; a write to the spare index changes nothing
    cfg_write(REG_MODE, {29'd0, MODE_UNUSED});
    send_vertex(COORD_MAX, COORD_MIN, 32'h5a5a5a5a, 1'b1);
    cfg_write(REG_UNUSED, $urandom());
    send_vertex(32'ha5a5a5a5, COORD_MAX, COORD_MIN, 1'b0);

    // random segments: each one a fresh setting and a stream of vertices;
    // the sender idles rarely, then often, then never
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        idle_pct = 20;
      end else if (seg < 2 * SEGMENTS / 3) begin
        idle_pct = 84;
      end else begin
        idle_pct = 0;
      end
      if ($urandom_range(0, 19) == 0) begin
        m = MODE_UNUSED;
      end else begin
        m = 3'($urandom_range(0, 6));
      end
      cfg_write(REG_MODE, {29'd0, m});
      if (m <= MODE_ROTZ || $urandom_range(0, 3) == 0) cfg_write(REG_ANGLE, rand_angle());
      if ($urandom_range(0, 2) != 0) cfg_write(REG_FACTOR, rand_factor());
      for (item = 0; item < SEG_ITEMS; item++) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord(),
                    item == SEG_ITEMS - 1 || $urandom_range(0, 9) == 0);
        // gap after the transfer edge, of random length
        while ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
    end

    drain();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
